// File: sv/ats_pkg.sv
package ats_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 256;
	localparam int unsigned COEF_W = 32;
	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_XFORM = 2'd2,
		OP_RESET = 2'd3
	} op_t;

	// back end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_MUL, ST_SUM, ST_DONE
	} st_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] ma;
		logic signed [31:0] mb;
		logic signed [31:0] mc;
		logic signed [31:0] md;
		logic signed [31:0] me;
		logic signed [31:0] mf;
		logic signed [31:0] px;
		logic signed [31:0] py;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               dropped;
		logic [7:0]         level;
	} res_t;

	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [31:0] d;
		logic signed [31:0] e;
		logic signed [31:0] f;
	} mat_t;

	// round half up of the q32.32 sum, add the q16.16 term, saturate
	function automatic logic signed [31:0] fin(input logic signed [64:0] s,
		input logic signed [31:0] t);
		logic signed [50:0] r;
		r = 51'($signed(s[64:16])) + 51'(s[15]) + 51'(t);
		if (r > 51'(SAT_MAX))
			fin = SAT_MAX;
		else if (r < 51'(SAT_MIN))
			fin = SAT_MIN;
		else
			fin = r[31:0];
	endfunction

endpackage

// File: sv/affine_transform_stack_top.sv
// Stack of 2D affine matrices in signed Q16.16, level zero identity after reset.
// A command word is queued at the front; the back end reads the top matrix,
// then computes each output term in a multiply state and a round-and-saturate
// state through one pair of 32x32 multipliers: a push that is not dropped computes
// six terms, transform two, pop and reset none. Each word gives one result word.
module affine_transform_stack_top import ats_pkg::*; #(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [1:0] opcode,
	input  logic signed [31:0] coef_a,
	input  logic signed [31:0] coef_b,
	input  logic signed [31:0] coef_c,
	input  logic signed [31:0] coef_d,
	input  logic signed [31:0] coef_e,
	input  logic signed [31:0] coef_f,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	output logic empty,
	input  logic pop,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic push_dropped,
	output logic [7:0] level
);
	cmd_t cin, cq;
	logic cv, ct, rv;
	res_t r;

	assign cin = cmd_t'{op_t'(opcode), coef_a, coef_b, coef_c, coef_d, coef_e, coef_f,
		point_x, point_y};

	ats_front u_front (.clk, .arst_n, .push, .full, .cmd_in(cin), .cmd_valid(cv),
		.cmd_take(ct), .cmd_out(cq));

	ats_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (.clk, .arst_n, .cmd_valid(cv),
		.cmd_take(ct), .cmd(cq), .res_valid(rv), .res_take(pop), .res(r));

	assign empty = !rv;
	assign out_x = r.x;
	assign out_y = r.y;
	assign push_dropped = r.dropped;
	assign level = r.level;
endmodule

// File: sv/ats_front.sv
// input queue: takes words and holds them for the back end
module ats_front import ats_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  cmd_t cmd_in,
	output logic cmd_valid,
	input  logic cmd_take,
	output cmd_t cmd_out
);
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign full = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_out = mem_q[rp_q];
	assign wr = push && !full;
	assign rd = cmd_take && cmd_valid;

	// storage
	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= cmd_in;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr)
				wp_q <= !wp_q;
			if (rd)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule

// File: sv/ats_back.sv
// executes one command: reads top matrix, multiplies term by term, writes back a pushed matrix
module ats_back import ats_pkg::*; #(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_take,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_take,
	output res_t res
);
	localparam int unsigned LW = $clog2(STACK_DEPTH);

	st_t st_q, st_nx;
	mat_t mem_q [STACK_DEPTH];
	mat_t top_q;
	cmd_t cmd_q;
	logic [LW-1:0] lvl_q;
	logic          id0_q;
	logic [2:0]    k_q;
	logic signed [63:0] p1_s1, p2_s1;
	logic signed [31:0] t_s1;
	logic signed [31:0] acc_q [6];
	res_t res_q;
	logic rv_q;
	logic wr_en;
	logic [LW-1:0] wr_addr;
	mat_t wr_data;
	logic signed [31:0] ta, tb, fa, fb, tt;
	mat_t top;
	logic full_stk;

	assign top = (lvl_q == '0 && id0_q) ?
		mat_t'{ONE_Q16, 32'sd0, 32'sd0, ONE_Q16, 32'sd0, 32'sd0} : top_q;
	assign full_stk = (lvl_q == LW'(STACK_DEPTH - 1));
	assign cmd_take = (st_q == ST_IDLE) && cmd_valid && !rv_q;
	assign res_valid = rv_q;
	assign res = res_q;

	// next state
	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			ST_IDLE: if (cmd_take) st_nx = ST_READ;
			ST_READ: begin
				if ((cmd_q.op == OP_PUSH && !full_stk) || cmd_q.op == OP_XFORM)
					st_nx = ST_MUL;
				else
					st_nx = ST_DONE;
			end
			ST_MUL: st_nx = ST_SUM;
			ST_SUM: st_nx = (k_q == 3'd5 || (cmd_q.op == OP_XFORM && k_q == 3'd1)) ?
				ST_DONE : ST_MUL;
			ST_DONE: st_nx = ST_IDLE;
			default: st_nx = ST_IDLE;
		endcase
	end

	// operand selection for term k: out = t(ta)*fa + t(tb)*fb + tt
	always_comb begin
		ta = k_q[0] ? top.b : top.a;
		tb = k_q[0] ? top.d : top.c;
		tt = '0;
		fa = cmd_q.px;
		fb = cmd_q.py;
		if (cmd_q.op == OP_XFORM) begin
			tt = k_q[0] ? top.f : top.e;
		end else begin
			unique case (k_q[2:1])
				2'd0: begin fa = cmd_q.ma; fb = cmd_q.mb; end
				2'd1: begin fa = cmd_q.mc; fb = cmd_q.md; end
				default: begin
					fa = cmd_q.me; fb = cmd_q.mf;
					tt = k_q[0] ? top.f : top.e;
				end
			endcase
		end
	end

	// write-back data
	always_comb begin
		wr_en = (st_q == ST_DONE) && cmd_q.op == OP_PUSH && !full_stk;
		wr_addr = lvl_q + LW'(1);
		wr_data = mat_t'{acc_q[0], acc_q[1], acc_q[2], acc_q[3], acc_q[4], acc_q[5]};
	end

	// stack memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (st_q == ST_IDLE)
			top_q <= mem_q[lvl_q];
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cmd_take)
			cmd_q <= cmd;
		if (st_q == ST_MUL) begin
			p1_s1 <= 64'(ta) * 64'(fa);
			p2_s1 <= 64'(tb) * 64'(fb);
			t_s1 <= tt;
		end
		if (st_q == ST_SUM)
			acc_q[k_q] <= fin(65'(p1_s1) + 65'(p2_s1), t_s1);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			lvl_q <= '0;
			id0_q <= 1'b1;
			k_q <= '0;
			rv_q <= 1'b0;
			res_q <= '0;
		end else begin
			st_q <= st_nx;
			if (st_q == ST_READ)
				k_q <= '0;
			else if (st_q == ST_SUM)
				k_q <= k_q + 3'd1;
			if (res_take && rv_q)
				rv_q <= 1'b0;
			if (st_q == ST_DONE) begin
				rv_q <= 1'b1;
				unique case (cmd_q.op)
					OP_PUSH: begin
						res_q.x <= '0;
						res_q.y <= '0;
						if (full_stk) begin
							res_q.dropped <= 1'b1;
							res_q.level <= 8'(lvl_q);
						end else begin
							res_q.dropped <= 1'b0;
							lvl_q <= lvl_q + LW'(1);
							res_q.level <= 8'(lvl_q + LW'(1));
						end
					end
					OP_POP: begin
						res_q.x <= '0;
						res_q.y <= '0;
						res_q.dropped <= 1'b0;
						if (lvl_q != '0)
							lvl_q <= lvl_q - LW'(1);
						res_q.level <= 8'((lvl_q != '0) ? lvl_q - LW'(1) : lvl_q);
					end
					OP_XFORM: begin
						res_q.x <= acc_q[0];
						res_q.y <= acc_q[1];
						res_q.dropped <= 1'b0;
						res_q.level <= 8'(lvl_q);
					end
					default: begin
						res_q.x <= '0;
						res_q.y <= '0;
						res_q.dropped <= 1'b0;
						lvl_q <= '0;
						id0_q <= 1'b1;
						res_q.level <= '0;
					end
				endcase
			end
			if (wr_en && wr_addr == '0)
				id0_q <= 1'b0;
		end
	end
endmodule

// File: sv/ats_check.sv
// port-level checks
module ats_check (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic signed [31:0] out_x,
	input logic signed [31:0] out_y,
	input logic push_dropped
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_x)))
		else $error("result word changed while waiting");
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && push_dropped) |-> (out_x == 0 && out_y == 0))
		else $error("dropped push carries coordinates");
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop) |=> empty)
		else $error("results closer than back end allows");
endmodule

bind affine_transform_stack_top ats_check u_check (.clk, .arst_n, .empty, .pop, .out_x,
	.out_y, .push_dropped);
